/* sv/csvft_pkg.sv */
// shared types, byte codes and result helpers for the csv field tokenizer
package csvft_pkg;

  // byte codes with a fixed meaning
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // configuration register indexes and reset values
  localparam logic CFG_DELIMITER  = 1'b0;
  localparam logic CFG_QUOTE_CHAR = 1'b1;
  localparam logic [7:0] DELIMITER_RST  = 8'd44;
  localparam logic [7:0] QUOTE_CHAR_RST = 8'd34;

  // one result transaction
  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       field_end;
    logic       row_end;
    logic       last;
  } ev_t;

  // results of one accepted input, handed from the parser to the output buffer
  typedef struct packed {
    logic [1:0] n;
    ev_t        e0;
    ev_t        e1;
  } push_t;

  function automatic ev_t ev_char(input logic [7:0] c);
    ev_t e;
    e = '0;
    e.has_char = 1'b1;
    e.out_char = c;
    return e;
  endfunction

  function automatic ev_t ev_field_end();
    ev_t e;
    e = '0;
    e.field_end = 1'b1;
    return e;
  endfunction

  function automatic ev_t ev_row_end();
    ev_t e;
    e = '0;
    e.row_end = 1'b1;
    return e;
  endfunction

endpackage

/* sv/csvft_parse.sv */
// parser state and per-byte decode into up to two result transactions
module csvft_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           ch,
  input  logic                 end_of_data,
  input  logic [7:0]           delimiter,
  input  logic [7:0]           quote_char,
  output csvft_pkg::push_t     push
);
  import csvft_pkg::*;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_UNQ   = 3'd1,
    ST_INQ   = 3'd2,
    ST_QSEEN = 3'd3,
    ST_AFTER = 3'd4
  } state_t;

  state_t state_r, state_nxt;
  logic   blank_r, blank_nxt;
  logic   row_r, row_nxt;

  logic   is_blank;
  logic   pending;
  logic   run_after;
  logic   run_start;
  logic   pre_v;
  logic   main_v;
  ev_t    main_ev;

  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);

  // a field is open unless we sit after a field or at a clean field start
  assign pending = (state_r == ST_UNQ) || (state_r == ST_INQ) || (state_r == ST_QSEEN) ||
                   ((state_r != ST_AFTER) && blank_r);

  // next state and the two result slots: an optional field end, then the main result
  always_comb begin
    state_nxt = state_r;
    blank_nxt = blank_r;
    row_nxt   = row_r;
    pre_v     = 1'b0;
    main_v    = 1'b0;
    main_ev   = '0;
    run_after = 1'b0;
    run_start = 1'b0;

    if (end_of_data || (ch == CH_LF)) begin
      // nothing pending at end of data gives no result
      if (!end_of_data || row_r || (state_r != ST_START) || blank_r) begin
        pre_v     = pending;
        main_v    = 1'b1;
        main_ev   = ev_row_end();
        state_nxt = ST_START;
        blank_nxt = 1'b0;
        row_nxt   = 1'b0;
      end
    end else begin
      row_nxt = 1'b1;
      unique case (state_r)
        ST_UNQ: begin
          priority if (ch == delimiter) begin
            main_v    = 1'b1;
            main_ev   = ev_field_end();
            state_nxt = ST_START;
            blank_nxt = 1'b0;
          end else if (ch == CH_CR) begin
            main_v    = 1'b1;
            main_ev   = ev_field_end();
            state_nxt = ST_AFTER;
          end else begin
            main_v    = 1'b1;
            main_ev   = ev_char(ch);
          end
        end
        ST_INQ: begin
          if (ch == quote_char) begin
            state_nxt = ST_QSEEN;
          end else begin
            main_v  = 1'b1;
            main_ev = ev_char(ch);
          end
        end
        ST_QSEEN: begin
          if (ch == quote_char) begin
            // doubled quote stands for one quote byte
            main_v    = 1'b1;
            main_ev   = ev_char(ch);
            state_nxt = ST_INQ;
          end else begin
            pre_v     = 1'b1;
            run_after = 1'b1;
          end
        end
        ST_AFTER: begin
          run_after = 1'b1;
        end
        default: begin
          run_start = 1'b1;
        end
      endcase

      // after a closed field: drop blanks and carriage return, delimiter opens next field
      if (run_after) begin
        state_nxt = ST_AFTER;
        blank_nxt = 1'b0;
        priority if (is_blank) begin
          state_nxt = ST_AFTER;
        end else if (ch == delimiter) begin
          state_nxt = ST_START;
        end else if (ch == CH_CR) begin
          state_nxt = ST_AFTER;
        end else begin
          run_start = 1'b1;
        end
      end

      // first byte of a field
      if (run_start) begin
        priority if (is_blank) begin
          blank_nxt = 1'b1;
          state_nxt = ST_START;
        end else if (ch == quote_char) begin
          blank_nxt = 1'b0;
          state_nxt = ST_INQ;
        end else if (ch == delimiter) begin
          blank_nxt = 1'b0;
          main_v    = 1'b1;
          main_ev   = ev_field_end();
          state_nxt = ST_START;
        end else if (ch == CH_CR) begin
          blank_nxt = 1'b0;
          main_v    = 1'b1;
          main_ev   = ev_field_end();
          state_nxt = ST_AFTER;
        end else begin
          blank_nxt = 1'b0;
          main_v    = 1'b1;
          main_ev   = ev_char(ch);
          state_nxt = ST_UNQ;
        end
      end
    end
  end

  // pack the slots, last mark on the final one
  always_comb begin
    push    = '0;
    push.e0 = '0;
    push.e1 = '0;
    if (pre_v && main_v) begin
      push.n       = 2'd2;
      push.e0      = ev_field_end();
      push.e1      = main_ev;
      push.e1.last = 1'b1;
    end else if (pre_v) begin
      push.n       = 2'd1;
      push.e0      = ev_field_end();
      push.e0.last = 1'b1;
    end else if (main_v) begin
      push.n       = 2'd1;
      push.e0      = main_ev;
      push.e0.last = 1'b1;
    end
    if (!accept) begin
      push.n = 2'd0;
    end
  end

  // parser state, updated on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      blank_r <= 1'b0;
      row_r   <= 1'b0;
    end else if (accept) begin
      state_r <= state_nxt;
      blank_r <= blank_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

/* sv/csvft_obuf.sv */
// two-entry result buffer between the parser and the output channel
module csvft_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  csvft_pkg::push_t  push,
  input  logic              out_tready,
  output logic              out_tvalid,
  output csvft_pkg::ev_t    head,
  output logic              room
);
  import csvft_pkg::*;

  ev_t        q_r [2];
  ev_t        q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] base;
  logic       pop;

  assign out_tvalid = (cnt_r != 2'd0);
  assign head       = q_r[0];
  assign pop        = out_tvalid && out_tready;
  // an input may cause two results, so two slots must be free after this cycle's pop
  assign room       = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign base       = cnt_r - {1'b0, pop};

  // shift on pop, then append the new results behind what is left
  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (push.n != 2'd0) begin
      q_nxt[base[0]] = push.e0;
    end
    if (push.n == 2'd2) begin
      q_nxt[1] = push.e1;
    end
    cnt_nxt = base + push.n;
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // result slots
  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("result buffer overfilled");
  a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop)))
    else $error("two results pushed without two free slots");
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |=> out_tvalid)
    else $error("pushed result not presented");
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !head.last) |=> out_tvalid)
    else $error("second result of a transaction missing");
`endif

endmodule

/* sv/csv_field_tokenizer.sv */
// top level of the csv field tokenizer: config registers, parser and result buffer
//
//  channel  dir  tdata           tuser                          tlast
//  in_      in   ch              end_of_data                    -
//  out_     out  out_char        has_char, field_end, row_end   last
//  cfg_     in   write data      index 0 delimiter, 1 quote_char
//
// one input transaction per cycle while in_tready is high; each causes zero,
// one or two results, handed out as separate output transactions. in_tready is
// low whenever the two-slot result buffer would not keep two free slots after
// this cycle's pop; it follows out_tready combinationally when one result waits.
// synchronous active-low reset clears parser state and the buffer count and
// restores delimiter 44 and quote_char 34.
module csv_field_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // ch
  input  logic       in_tuser,   // end_of_data
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_char
  output logic [2:0] out_tuser,  // has_char, field_end, row_end
  output logic       out_tlast,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_wdata
);
  import csvft_pkg::*;

  logic [7:0] delimiter_r;
  logic [7:0] quote_char_r;
  logic       accept;
  push_t      push;
  ev_t        head;
  logic       room;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r  <= DELIMITER_RST;
      quote_char_r <= QUOTE_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DELIMITER:  delimiter_r  <= cfg_wdata;
        CFG_QUOTE_CHAR: quote_char_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = room;
  assign accept    = in_tvalid && room;

  csvft_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .ch          (in_tdata),
    .end_of_data (in_tuser),
    .delimiter   (delimiter_r),
    .quote_char  (quote_char_r),
    .push        (push)
  );

  csvft_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .head       (head),
    .room       (room)
  );

  // output packing
  assign out_tdata = head.out_char;
  assign out_tuser = {head.row_end, head.field_end, head.has_char};
  assign out_tlast = head.last;

endmodule
